// File: src/mcfp_pkg.sv
package mcfp_pkg;

  // Number of motors served by the command set
  localparam int MOTOR_COUNT = 2;

  // Framing characters
  localparam logic [7:0] CH_OPEN  = 8'h24;
  localparam logic [7:0] CH_CLOSE = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Motor command codes: first three payload bytes
  localparam logic [23:0] CODE_M1F = 24'h4d3146;
  localparam logic [23:0] CODE_M1R = 24'h4d3152;
  localparam logic [23:0] CODE_M1B = 24'h4d3142;
  localparam logic [23:0] CODE_M2F = 24'h4d3246;
  localparam logic [23:0] CODE_M2R = 24'h4d3252;
  localparam logic [23:0] CODE_M2B = 24'h4d3242;

  // Gain command letters
  localparam logic [7:0] GAIN_P = 8'h50;
  localparam logic [7:0] GAIN_I = 8'h49;
  localparam logic [7:0] GAIN_D = 8'h44;

  // Gain selections
  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_I = 2'd1;
  localparam logic [1:0] SEL_D = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_MOTOR_OK   = 3'd0;
  localparam logic [2:0] ST_GAIN_OK    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN    = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_DIGIT  = 3'd4;

  // Payload depth and saturated count meaning overflow
  localparam int PAYLOAD_DEPTH = 8;
  localparam logic [3:0] COUNT_OVERFLOW = 4'd9;

  // Motor flag bit positions
  localparam int FL_FWD = 0;
  localparam int FL_REV = 1;
  localparam int FL_BRK = 2;

  // One closed frame handed from the framer to the executor
  typedef struct packed {
    logic [PAYLOAD_DEPTH-1:0][7:0] data;
    logic [3:0]                    len;
  } frame_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: src/mcfp_ifs.sv
interface mcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        motor_sel;
  logic        run_forward;
  logic        run_reverse;
  logic        braking;
  logic        dir_change;
  logic [16:0] set_speed;
  logic [1:0]  gain_sel;
  logic [13:0] gain_value;

  modport source (output valid, output status, output motor_sel, output run_forward,
                  output run_reverse, output braking, output dir_change, output set_speed,
                  output gain_sel, output gain_value, input ready);
  modport sink (input valid, input status, input motor_sel, input run_forward,
                input run_reverse, input braking, input dir_change, input set_speed,
                input gain_sel, input gain_value, output ready);
endinterface

// File: src/motor_command_frame_parser_core.sv
// Serial command frame parser for two motors. One ASCII byte is taken per
// cycle while ready is high; '$' opens a frame, '*' closes it, and every close
// of an open frame gives exactly one result transaction (motor command, P/I/D
// gain command, or an error status for unknown command, bad length or bad
// digit). The framer hands the closed frame to a two-entry frame queue, and
// the executor decodes it into a result register. The input keeps taking
// bytes while the output stalls, until two decoded-pending frames fill the
// queue; then ready drops until the executor drains an entry.
module motor_command_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  mcfp_in_if.sink     in_ch,
  mcfp_out_if.source  out_ch
);

  logic             push;
  logic             push_ready;
  mcfp_pkg::frame_t push_frame;
  logic             q_valid;
  logic             q_pop;
  mcfp_pkg::frame_t q_frame;

  mcfp_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_frame (push_frame),
    .push_ready (push_ready)
  );

  mcfp_frame_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_frame  (q_frame),
    .pop        (q_pop)
  );

  mcfp_executor u_exec (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (q_valid),
    .frame       (q_frame),
    .pop         (q_pop),
    .out_ch      (out_ch)
  );

`ifndef ASSERT_OFF
  // A popped frame shows up as a valid result on the next cycle
  a_pop_to_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_ch.valid)
    else $error("popped frame produced no result");

  // Motor fields stay zero unless the result is a motor command
  a_motor_fields: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != mcfp_pkg::ST_MOTOR_OK) |->
      (out_ch.set_speed == 17'd0 && !out_ch.run_forward && !out_ch.run_reverse &&
       !out_ch.braking && !out_ch.dir_change && !out_ch.motor_sel))
    else $error("motor fields set on non-motor result");

  // A successful motor command leaves exactly one flag set
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == mcfp_pkg::ST_MOTOR_OK) |->
      $onehot({out_ch.run_forward, out_ch.run_reverse, out_ch.braking}))
    else $error("motor result without exactly one flag");

  // Gain value stays within four decimal digits
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.gain_value <= 14'd9999))
    else $error("gain value out of range");
`endif

endmodule

// File: src/mcfp_framer.sv
module mcfp_framer (
  input  logic               clk,
  input  logic               rst,
  mcfp_in_if.sink            in_ch,
  output logic               push,
  output mcfp_pkg::frame_t   push_frame,
  input  logic               push_ready
);

  logic                 in_frame;
  logic [3:0]           count;
  logic [7:0][7:0]      store;
  logic                 accept;
  logic                 is_open;
  logic                 is_close;

  // Take a byte whenever the queue can absorb a closing frame
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_open     = in_ch.rx_byte == mcfp_pkg::CH_OPEN;
  assign is_close    = in_ch.rx_byte == mcfp_pkg::CH_CLOSE;

  // Hand a closed frame to the queue
  assign push            = accept && !is_open && in_frame && is_close;
  assign push_frame.data = store;
  assign push_frame.len  = count;

  // Track frame state and payload count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      count    <= '0;
    end else if (accept) begin
      if (is_open) begin
        in_frame <= 1'b1;
        count    <= '0;
      end else if (in_frame) begin
        if (is_close) begin
          in_frame <= 1'b0;
          count    <= '0;
        end else if (count < mcfp_pkg::COUNT_OVERFLOW) begin
          count <= count + 4'd1;
        end
      end
    end
  end

  // Store payload bytes; drop anything past the eighth
  always_ff @(posedge clk) begin
    if (accept && !is_open && in_frame && !is_close && !count[3]) begin
      store[count[2:0]] <= in_ch.rx_byte;
    end
  end

endmodule

// File: src/mcfp_frame_queue.sv
module mcfp_frame_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mcfp_pkg::frame_t push_frame,
  output logic             push_ready,
  output logic             pop_valid,
  output mcfp_pkg::frame_t pop_frame,
  input  logic             pop
);

  mcfp_pkg::frame_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_frame  = entries[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Write entry
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_frame;
  end

endmodule

// File: src/mcfp_executor.sv
module mcfp_executor (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  input  mcfp_pkg::frame_t frame,
  output logic             pop,
  mcfp_out_if.source       out_ch
);

  logic [2:0]  motor_flags [2];
  logic [16:0] motor_speed [2];
  logic [3:0]  kept_thousands;

  logic        out_valid;
  logic [2:0]  r_status;
  logic        r_motor_sel;
  logic        r_fwd;
  logic        r_rev;
  logic        r_brk;
  logic        r_dchg;
  logic [16:0] r_speed;
  logic [1:0]  r_gain_sel;
  logic [13:0] r_gain_value;

  logic [7:0][7:0] b;
  logic [23:0] code;
  logic        hit;
  logic        m;
  logic [1:0]  kind;
  logic        spd_ok;
  logic [16:0] spd_val;
  logic [2:0]  f_old;
  logic        gain_hit;
  logic [1:0]  gsel;
  logic        gdig_ok;
  logic [3:0]  kept_eff;
  logic [3:0]  g_h;
  logic [3:0]  g_t;
  logic [3:0]  g_o;

  logic        upd_motor;
  logic        upd_speed;
  logic        upd_kept;
  logic [2:0]  n_status;
  logic        n_motor_sel;
  logic [2:0]  n_flags;
  logic        n_dchg;
  logic [16:0] n_speed;
  logic [1:0]  n_gain_sel;
  logic [13:0] n_gain_value;

  localparam logic [1:0] KIND_FWD = 2'd0;
  localparam logic [1:0] KIND_REV = 2'd1;
  localparam logic [1:0] KIND_BRK = 2'd2;

  // Take the next frame when the result register is free or being drained
  assign pop  = frame_valid && (!out_valid || out_ch.ready);
  assign b    = frame.data;
  assign code = {b[0], b[1], b[2]};

  // Classify motor code
  always_comb begin
    hit  = 1'b1;
    m    = 1'b0;
    kind = KIND_FWD;
    case (code)
      mcfp_pkg::CODE_M1F: begin m = 1'b0; kind = KIND_FWD; end
      mcfp_pkg::CODE_M1R: begin m = 1'b0; kind = KIND_REV; end
      mcfp_pkg::CODE_M1B: begin m = 1'b0; kind = KIND_BRK; end
      mcfp_pkg::CODE_M2F: begin m = 1'b1; kind = KIND_FWD; end
      mcfp_pkg::CODE_M2R: begin m = 1'b1; kind = KIND_REV; end
      mcfp_pkg::CODE_M2B: begin m = 1'b1; kind = KIND_BRK; end
      default:            hit = 1'b0;
    endcase
  end

  // Speed digits: bytes three to seven
  assign spd_ok = mcfp_pkg::is_digit(b[3]) && mcfp_pkg::is_digit(b[4]) &&
                  mcfp_pkg::is_digit(b[5]) && mcfp_pkg::is_digit(b[6]) &&
                  mcfp_pkg::is_digit(b[7]);
  assign spd_val = 17'(b[3][3:0]) * 17'd10000 + 17'(b[4][3:0]) * 17'd1000 +
                   17'(b[5][3:0]) * 17'd100 + 17'(b[6][3:0]) * 17'd10 +
                   17'(b[7][3:0]);
  assign f_old = motor_flags[m];

  // Classify gain letter
  always_comb begin
    gain_hit = 1'b1;
    gsel     = mcfp_pkg::SEL_P;
    case (b[0])
      mcfp_pkg::GAIN_P: gsel = mcfp_pkg::SEL_P;
      mcfp_pkg::GAIN_I: gsel = mcfp_pkg::SEL_I;
      mcfp_pkg::GAIN_D: gsel = mcfp_pkg::SEL_D;
      default:          gain_hit = 1'b0;
    endcase
  end

  // Gain digits: last three bytes carry the value; a fifth byte gives a thousands digit, kept and added to D gains
  assign gdig_ok = mcfp_pkg::is_digit(b[1]) && mcfp_pkg::is_digit(b[2]) &&
                   mcfp_pkg::is_digit(b[3]) &&
                   (frame.len != 4'd5 || mcfp_pkg::is_digit(b[4]));
  assign kept_eff = (frame.len == 4'd5) ? b[1][3:0] : kept_thousands;
  assign g_h = (frame.len == 4'd5) ? b[2][3:0] : b[1][3:0];
  assign g_t = (frame.len == 4'd5) ? b[3][3:0] : b[2][3:0];
  assign g_o = (frame.len == 4'd5) ? b[4][3:0] : b[3][3:0];

  // Decode the frame into one result and its state updates
  always_comb begin
    upd_motor    = 1'b0;
    upd_speed    = 1'b0;
    upd_kept     = 1'b0;
    n_status     = mcfp_pkg::ST_BAD_LENGTH;
    n_motor_sel  = 1'b0;
    n_flags      = '0;
    n_dchg       = 1'b0;
    n_speed      = '0;
    n_gain_sel   = '0;
    n_gain_value = '0;
    if (frame.len == 4'd8) begin
      if (!hit || (32'(m) >= mcfp_pkg::MOTOR_COUNT)) begin
        n_status = mcfp_pkg::ST_UNKNOWN;
      end else if (kind != KIND_BRK && !spd_ok) begin
        n_status = mcfp_pkg::ST_BAD_DIGIT;
      end else begin
        n_status    = mcfp_pkg::ST_MOTOR_OK;
        n_motor_sel = m;
        upd_motor   = 1'b1;
        n_speed     = motor_speed[m];
        case (kind)
          KIND_FWD: begin
            n_flags   = 3'b001;
            n_dchg    = f_old[mcfp_pkg::FL_REV] && !f_old[mcfp_pkg::FL_FWD];
            n_speed   = spd_val;
            upd_speed = 1'b1;
          end
          KIND_REV: begin
            n_flags   = 3'b010;
            n_dchg    = f_old[mcfp_pkg::FL_FWD] && !f_old[mcfp_pkg::FL_REV];
            n_speed   = spd_val;
            upd_speed = 1'b1;
          end
          default: n_flags = 3'b100;
        endcase
      end
    end else if (frame.len == 4'd4 || frame.len == 4'd5) begin
      if (!gain_hit) begin
        n_status = mcfp_pkg::ST_UNKNOWN;
      end else if (!gdig_ok) begin
        n_status = mcfp_pkg::ST_BAD_DIGIT;
      end else begin
        n_status     = mcfp_pkg::ST_GAIN_OK;
        upd_kept     = frame.len == 4'd5;
        n_gain_sel   = gsel;
        n_gain_value = 14'(g_h) * 14'd100 + 14'(g_t) * 14'd10 + 14'(g_o) +
                       ((gsel == mcfp_pkg::SEL_D) ? 14'(kept_eff) * 14'd1000 : 14'd0);
      end
    end
  end

  // Update motor and gain state
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_flags[0] <= '0;
      motor_flags[1] <= '0;
      motor_speed[0] <= '0;
      motor_speed[1] <= '0;
      kept_thousands <= '0;
    end else if (pop) begin
      if (upd_motor) motor_flags[m] <= n_flags;
      if (upd_speed) motor_speed[m] <= spd_val;
      if (upd_kept)  kept_thousands <= b[1][3:0];
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_status     <= n_status;
      r_motor_sel  <= n_motor_sel;
      r_fwd        <= n_flags[mcfp_pkg::FL_FWD];
      r_rev        <= n_flags[mcfp_pkg::FL_REV];
      r_brk        <= n_flags[mcfp_pkg::FL_BRK];
      r_dchg       <= n_dchg;
      r_speed      <= n_speed;
      r_gain_sel   <= n_gain_sel;
      r_gain_value <= n_gain_value;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = r_status;
  assign out_ch.motor_sel   = r_motor_sel;
  assign out_ch.run_forward = r_fwd;
  assign out_ch.run_reverse = r_rev;
  assign out_ch.braking     = r_brk;
  assign out_ch.dir_change  = r_dchg;
  assign out_ch.set_speed   = r_speed;
  assign out_ch.gain_sel    = r_gain_sel;
  assign out_ch.gain_value  = r_gain_value;

endmodule

// File: verif/tb_motor_command_frame_parser_core.sv
`timescale 1ns / 100ps

module tb_motor_command_frame_parser_core;
  import mcfp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1000;
  localparam int MAX_REPORTS  = 10;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [1:0] {OP_FWD, OP_REV, OP_BRK} motor_op_t;

  // One decoded frame as seen on the output channel
  typedef struct packed {
    logic [2:0]  status;
    logic        motor_sel;
    logic        run_forward;
    logic        run_reverse;
    logic        braking;
    logic        dir_change;
    logic [16:0] set_speed;
    logic [1:0]  gain_sel;
    logic [13:0] gain_value;
  } reply_t;

  logic clk;
  logic rst;

  mcfp_in_if  in_ch();
  mcfp_out_if out_ch();

  motor_command_frame_parser_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Parser state mirrored by the predictor
  logic        in_frame;
  logic [7:0]  frame_bytes [PAYLOAD_DEPTH];
  logic [3:0]  frame_len;
  logic [2:0]  motor_flags [2];
  logic [16:0] motor_speed [2];
  logic [3:0]  kept_thousands;

  reply_t expected_replies[$];

  int src_idle_pct;
  int snk_stall_pct;
  int bytes_sent;
  int mismatch_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit all_digits(input int first, input int cnt);
    for (int k = 0; k < cnt; k++)
      if (!is_dec(frame_bytes[first + k])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned digit_value(input int first, input int cnt);
    int unsigned v;
    v = 0;
    for (int k = 0; k < cnt; k++)
      v = v * 10 + int'(frame_bytes[first + k] - CH_ZERO);
    return v;
  endfunction

  function automatic void clear_parser_state();
    in_frame = 1'b0;
    frame_len = '0;
    kept_thousands = '0;
    for (int k = 0; k < PAYLOAD_DEPTH; k++) frame_bytes[k] = '0;
    for (int k = 0; k < 2; k++) begin
      motor_flags[k] = '0;
      motor_speed[k] = '0;
    end
  endfunction

  // Advance the parser by one byte; queue a reply when a frame closes
  function automatic void parse_rx_byte(input logic [7:0] c);
    reply_t      r;
    logic [23:0] code;
    int          m;
    int          n;
    motor_op_t   op;
    logic [1:0]  sel;
    bit          known;
    logic [2:0]  f;
    int unsigned v;
    r = '0;
    m = 0;
    op = OP_BRK;
    sel = SEL_P;
    known = 1'b1;
    if (c == CH_OPEN) begin
      in_frame = 1'b1;
      frame_len = '0;
      return;
    end
    if (!in_frame) return;
    if (c != CH_CLOSE) begin
      if (frame_len < PAYLOAD_DEPTH) frame_bytes[frame_len[2:0]] = c;
      if (frame_len < COUNT_OVERFLOW) frame_len = frame_len + 4'd1;
      return;
    end
    in_frame = 1'b0;
    n = frame_len;
    frame_len = '0;
    if (n == 8) begin
      code = {frame_bytes[0], frame_bytes[1], frame_bytes[2]};
      case (code)
        CODE_M1F: begin m = 0; op = OP_FWD; end
        CODE_M1R: begin m = 0; op = OP_REV; end
        CODE_M1B: begin m = 0; op = OP_BRK; end
        CODE_M2F: begin m = 1; op = OP_FWD; end
        CODE_M2R: begin m = 1; op = OP_REV; end
        CODE_M2B: begin m = 1; op = OP_BRK; end
        default: known = 1'b0;
      endcase
      if (!known || m >= MOTOR_COUNT) begin
        r.status = ST_UNKNOWN;
      end else if (op != OP_BRK && !all_digits(3, 5)) begin
        r.status = ST_BAD_DIGIT;
      end else begin
        f = motor_flags[m];
        if (op == OP_BRK) begin
          f = '0;
          f[FL_BRK] = 1'b1;
        end else begin
          // Direction flips only when exactly the opposite run flag was set
          if (op == OP_FWD) r.dir_change = f[FL_REV] && !f[FL_FWD];
          else r.dir_change = f[FL_FWD] && !f[FL_REV];
          v = digit_value(3, 5);
          motor_speed[m] = v[16:0];
          f = '0;
          f[(op == OP_FWD) ? FL_FWD : FL_REV] = 1'b1;
        end
        motor_flags[m] = f;
        r.status      = ST_MOTOR_OK;
        r.motor_sel   = m[0];
        r.run_forward = f[FL_FWD];
        r.run_reverse = f[FL_REV];
        r.braking     = f[FL_BRK];
        r.set_speed   = motor_speed[m];
      end
    end else if (n == 4 || n == 5) begin
      case (frame_bytes[0])
        GAIN_P:  sel = SEL_P;
        GAIN_I:  sel = SEL_I;
        GAIN_D:  sel = SEL_D;
        default: known = 1'b0;
      endcase
      if (!known) begin
        r.status = ST_UNKNOWN;
      end else if (!all_digits(1, n - 1)) begin
        r.status = ST_BAD_DIGIT;
      end else begin
        if (n == 5) kept_thousands = 4'(frame_bytes[1] - CH_ZERO);
        v = digit_value(n - 3, 3);
        if (sel == SEL_D) v = v + kept_thousands * 1000;
        r.status     = ST_GAIN_OK;
        r.gain_sel   = sel;
        r.gain_value = v[13:0];
      end
    end else begin
      r.status = ST_BAD_LENGTH;
    end
    expected_replies.push_back(r);
  endfunction

  function automatic string reply_text(input reply_t r);
    return $sformatf("st=%0d m=%0d fwd=%0d rev=%0d brk=%0d dchg=%0d spd=%0d sel=%0d gain=%0d",
                     r.status, r.motor_sel, r.run_forward, r.run_reverse, r.braking,
                     r.dir_change, r.set_speed, r.gain_sel, r.gain_value);
  endfunction

  // Predict every byte transaction accepted by the block
  always @(posedge clk) begin
    if (rst) clear_parser_state();
    else if (in_ch.valid && in_ch.ready) parse_rx_byte(in_ch.rx_byte);
  end

  // Check each reply transaction against the oldest prediction
  always @(posedge clk) begin : reply_checker
    reply_t got;
    reply_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.status, out_ch.motor_sel, out_ch.run_forward, out_ch.run_reverse,
             out_ch.braking, out_ch.dir_change, out_ch.set_speed, out_ch.gain_sel,
             out_ch.gain_value};
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reply: %s", reply_text(got));
      end else begin
        want = expected_replies.pop_front();
        if (got.status      !== want.status      || got.motor_sel   !== want.motor_sel ||
            got.run_forward !== want.run_forward || got.run_reverse !== want.run_reverse ||
            got.braking     !== want.braking     || got.dir_change  !== want.dir_change ||
            got.set_speed   !== want.set_speed   || got.gain_sel    !== want.gain_sel ||
            got.gain_value  !== want.gain_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("reply mismatch: expected %s, actual %s", reply_text(want),
                     reply_text(got));
        end
      end
    end
  end

  // Stall the reply channel at the current rate
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[motor_command_frame_parser_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t body);
    send_byte(CH_OPEN);
    foreach (body[k]) send_byte(body[k]);
    send_byte(CH_CLOSE);
  endtask

  function automatic byte_q_t motor_frame(input logic [23:0] code, input int unsigned speed);
    byte_q_t     q;
    int unsigned p;
    q = {code[23:16], code[15:8], code[7:0]};
    p = 10000;
    repeat (5) begin
      q.push_back(CH_ZERO + 8'((speed / p) % 10));
      p = p / 10;
    end
    return q;
  endfunction

  function automatic byte_q_t gain_frame(input logic [7:0] letter, input int unsigned value,
                                         input int ndig);
    byte_q_t     q;
    int unsigned p;
    q = {letter};
    p = (ndig == 4) ? 1000 : 100;
    repeat (ndig) begin
      q.push_back(CH_ZERO + 8'((value / p) % 10));
      p = p / 10;
    end
    return q;
  endfunction

  function automatic logic [7:0] random_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_OPEN || b == CH_CLOSE);
    return b;
  endfunction

  function automatic logic [7:0] random_nondigit();
    logic [7:0] b;
    do b = random_body_byte(); while (is_dec(b));
    return b;
  endfunction

  function automatic byte_q_t random_motor_frame();
    logic [23:0] code;
    int unsigned speed;
    int          pick;
    case ($urandom_range(5))
      0: code = CODE_M1F;
      1: code = CODE_M1R;
      2: code = CODE_M1B;
      3: code = CODE_M2F;
      4: code = CODE_M2R;
      default: code = CODE_M2B;
    endcase
    pick = $urandom_range(9);
    speed = (pick == 0) ? 0 : (pick == 1) ? 99999 : $urandom_range(99999);
    return motor_frame(code, speed);
  endfunction

  function automatic byte_q_t random_gain_frame();
    logic [7:0] letter;
    int         ndig;
    case ($urandom_range(2))
      0: letter = GAIN_P;
      1: letter = GAIN_I;
      default: letter = GAIN_D;
    endcase
    ndig = $urandom_range(3, 4);
    return gain_frame(letter, $urandom_range((ndig == 4) ? 9999 : 999), ndig);
  endfunction

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic test_motor_commands();
    send_frame(motor_frame(CODE_M1F, 0));
    send_frame(motor_frame(CODE_M1F, 99999));
    // reverse a running motor
    send_frame(motor_frame(CODE_M1R, 12345));
    send_frame(motor_frame(CODE_M1B, 31416));
    // forward after a brake is no reversal
    send_frame(motor_frame(CODE_M1F, 500));
    send_frame(motor_frame(CODE_M2R, 54321));
    send_frame(motor_frame(CODE_M2F, 7));
    send_frame(motor_frame(CODE_M2B, 99999));
  endtask

  task automatic test_gain_commands();
    // short D before any long gain uses the cleared thousands digit
    send_frame(gain_frame(GAIN_D, 123, 3));
    send_frame(gain_frame(GAIN_P, 1234, 4));
    send_frame(gain_frame(GAIN_I, 999, 3));
    send_frame(gain_frame(GAIN_D, 9876, 4));
    send_frame(gain_frame(GAIN_D, 0, 3));
    send_frame(gain_frame(GAIN_I, 0, 4));
    send_frame(gain_frame(GAIN_P, 0, 3));
  endtask

  task automatic test_framing();
    byte_q_t body;
    int      bad_lens [8];
    bad_lens = '{0, 1, 2, 3, 6, 7, 9, 12};
    // close and junk outside a frame give nothing
    send_byte(CH_CLOSE);
    send_byte(8'hFF);
    send_byte(8'h00);
    // reopen drops the partial payload
    send_byte(CH_OPEN);
    send_byte("M");
    send_byte(CH_ZERO);
    send_frame(gain_frame(GAIN_P, 42, 3));
    // bad lengths, including overflow past the payload store
    foreach (bad_lens[i]) begin
      body = {};
      repeat (bad_lens[i]) body.push_back(CH_ZERO + 8'($urandom_range(9)));
      send_frame(body);
    end
  endtask

  task automatic test_error_status();
    byte_q_t body;
    // motor number beyond the motor count
    body = motor_frame(CODE_M1F, 1);
    body[1] = "3";
    send_frame(body);
    body = motor_frame(CODE_M2R, 2);
    body[0] = "X";
    send_frame(body);
    body = gain_frame(GAIN_P, 1, 3);
    body[0] = "Q";
    send_frame(body);
    body = gain_frame(GAIN_I, 1, 4);
    body[0] = "Z";
    send_frame(body);
    // digits just outside the decimal range
    body = motor_frame(CODE_M1F, 11111);
    body[3] = CH_ZERO - 8'd1;
    send_frame(body);
    body = motor_frame(CODE_M2R, 22222);
    body[7] = CH_NINE + 8'd1;
    send_frame(body);
    body = gain_frame(GAIN_D, 555, 3);
    body[2] = CH_NINE + 8'd1;
    send_frame(body);
    // a rejected long gain must not update the thousands digit
    body = gain_frame(GAIN_P, 7777, 4);
    body[1] = CH_ZERO - 8'd1;
    send_frame(body);
    send_frame(gain_frame(GAIN_D, 321, 3));
    // brake ignores its speed bytes
    body = motor_frame(CODE_M2B, 0);
    for (int k = 3; k < 8; k++) body[k] = random_nondigit();
    send_frame(body);
  endtask

  task automatic send_random_frame();
    byte_q_t body;
    int      r;
    r = $urandom_range(99);
    if (r < 40) begin
      body = random_motor_frame();
      if ($urandom_range(99) < 8) body[$urandom_range(3, 7)] = random_nondigit();
      if ($urandom_range(99) < 5) body[$urandom_range(2)] = random_body_byte();
      send_frame(body);
    end else if (r < 70) begin
      body = random_gain_frame();
      if ($urandom_range(99) < 8) body[$urandom_range(1, body.size() - 1)] = random_nondigit();
      if ($urandom_range(99) < 5) body[0] = random_body_byte();
      send_frame(body);
    end else if (r < 80) begin
      body = {};
      repeat ($urandom_range(12)) body.push_back(random_body_byte());
      send_frame(body);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end else if (r < 94) begin
      send_byte(CH_OPEN);
      repeat ($urandom_range(1, 6)) send_byte(random_body_byte());
      send_frame(($urandom_range(1) == 0) ? random_motor_frame() : random_gain_frame());
    end else begin
      send_byte(CH_CLOSE);
      repeat ($urandom_range(3)) send_byte(random_body_byte());
    end
  endtask

  task automatic test_random_traffic();
    int base;
    base = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(83, 0);
        2: set_idling(0, 83);
        default: set_idling(15, 15);
      endcase
      while (bytes_sent < base + (phase + 1) * RANDOM_BYTES / 4) send_random_frame();
    end
  endtask

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    bytes_sent     = 0;
    set_idling(0, 0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_motor_commands();
    test_gain_commands();
    test_framing();
    test_error_status();
    test_random_traffic();

    // drain outstanding replies, then watch for strays
    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("[motor_command_frame_parser_core] OK");
    end else begin
      $display("[motor_command_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule

// File: motor_command_frame_parser_core.f
src/mcfp_pkg.sv
src/mcfp_ifs.sv
src/mcfp_framer.sv
src/mcfp_frame_queue.sv
src/mcfp_executor.sv
src/motor_command_frame_parser_core.sv
verif/tb_motor_command_frame_parser_core.sv
